// ===== rtl/opn2d_pkg.sv =====
`default_nettype none
package opn2d_pkg;

   localparam int TABLE_SIZE  = 256;
   localparam int MAX_OCTAVES = 16;

   localparam logic [1:0] MODE_SINGLE = 2'd0;
   localparam logic [1:0] MODE_FBM    = 2'd1;
   localparam logic [1:0] MODE_RIDGED = 2'd2;
   localparam logic [1:0] MODE_SPARE  = 2'd3;

   localparam logic [1:0] CSR_MODE        = 2'd0;
   localparam logic [1:0] CSR_OCTAVES     = 2'd1;
   localparam logic [1:0] CSR_PERSISTENCE = 2'd2;
   localparam logic [1:0] CSR_LACUNARITY  = 2'd3;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_EVAL = 1'b1;

   // per-octave schedule
   localparam logic [4:0] PH_SCALE   = 5'd0;
   localparam logic [4:0] PH_ADDR_X  = 5'd1;
   localparam logic [4:0] PH_ADDR_X1 = 5'd2;
   localparam logic [4:0] PH_ADDR_A  = 5'd3;
   localparam logic [4:0] PH_ADDR_A1 = 5'd4;
   localparam logic [4:0] PH_ADDR_B  = 5'd5;
   localparam logic [4:0] PH_ADDR_B1 = 5'd6;
   localparam logic [4:0] PH_ADDR_AA = 5'd7;
   localparam logic [4:0] PH_ADDR_BA = 5'd8;
   localparam logic [4:0] PH_ADDR_AB = 5'd9;
   localparam logic [4:0] PH_ADDR_BB = 5'd10;
   localparam logic [4:0] PH_GRAD2   = 5'd11;
   localparam logic [4:0] PH_LERP_M  = 5'd12;
   localparam logic [4:0] PH_LERP_A  = 5'd13;
   localparam logic [4:0] PH_LERP2_M = 5'd14;
   localparam logic [4:0] PH_LERP2_A = 5'd15;
   localparam logic [4:0] PH_RIDGE   = 5'd16;
   localparam logic [4:0] PH_WEIGHT  = 5'd17;
   localparam logic [4:0] PH_ACC     = 5'd18;

   typedef struct packed {
      logic       tbl_we;
      logic       init;
      logic       run;
      logic [4:0] phase;
      logic       div_check;
      logic       div_step;
      logic [3:0] div_bit;
      logic       emit;
   } ctl_cmd_type;

   function automatic logic signed [18:0] grad_q16(input logic [2:0] h,
                                                   input logic signed [17:0] dx,
                                                   input logic signed [17:0] dy);
      logic signed [18:0] u;
      logic signed [18:0] v;
      u = h[2] ? 19'(dy) : 19'(dx);
      v = h[2] ? 19'(dx) : 19'(dy);
      return (h[0] ? -u : u) + (h[1] ? -v : v);
   endfunction

endpackage
`default_nettype wire

// ===== rtl/opn2d_ctrl.sv =====
`default_nettype none
module opn2d_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   input  wire logic                   req_op,
   input  wire logic [1:0]             noise_mode,
   input  wire logic [4:0]             octave_count,
   output opn2d_pkg::ctl_cmd_type      cmd,
   output logic                        busy,
   output logic                        rsp_valid
);
   import opn2d_pkg::*;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_OCT  = 3'd1;
   localparam logic [2:0] ST_DCHK = 3'd2;
   localparam logic [2:0] ST_DIV  = 3'd3;
   localparam logic [2:0] ST_DONE = 3'd4;

   logic [2:0] state_ff, state_in;
   logic [4:0] phase_ff, phase_in;
   logic [3:0] oct_ff, oct_in;
   logic [3:0] last_ff, last_in;
   logic [3:0] bit_ff, bit_in;
   logic       valid_ff, valid_in;
   logic [4:0] cnt;

   always_comb begin
      if (octave_count == 5'd0) begin
         cnt = 5'd1;
      end else if (octave_count > 5'(MAX_OCTAVES)) begin
         cnt = 5'(MAX_OCTAVES);
      end else begin
         cnt = octave_count;
      end
      if (noise_mode == MODE_SINGLE || noise_mode == MODE_SPARE) begin
         cnt = 5'd1;
      end
   end

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      oct_in = oct_ff;
      last_in = last_ff;
      bit_in = bit_ff;
      valid_in = 1'b0;
      cmd = '0;
      cmd.phase = phase_ff;
      cmd.div_bit = bit_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (req_op == OP_EVAL) begin
                  cmd.init = 1'b1;
                  last_in = 4'(cnt - 5'd1);
                  oct_in = '0;
                  phase_in = PH_SCALE;
                  state_in = ST_OCT;
               end else begin
                  cmd.tbl_we = 1'b1;
               end
            end
         end
         ST_OCT: begin
            cmd.run = 1'b1;
            if (phase_ff == PH_ACC) begin
               phase_in = PH_SCALE;
               if (oct_ff == last_ff) begin
                  state_in = ST_DCHK;
               end else begin
                  oct_in = oct_ff + 4'd1;
               end
            end else begin
               phase_in = phase_ff + 5'd1;
            end
         end
         ST_DCHK: begin
            cmd.div_check = 1'b1;
            bit_in = 4'd15;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (bit_ff == 4'd0) begin
               state_in = ST_DONE;
            end else begin
               bit_in = bit_ff - 4'd1;
            end
         end
         ST_DONE: begin
            cmd.emit = 1'b1;
            valid_in = 1'b1;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         phase_ff <= '0;
         oct_ff <= '0;
         last_ff <= '0;
         bit_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         oct_ff <= oct_in;
         last_ff <= last_in;
         bit_ff <= bit_in;
         valid_ff <= valid_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);
   assign rsp_valid = valid_ff;

endmodule
`default_nettype wire

// ===== rtl/opn2d_dp.sv =====
`default_nettype none
module opn2d_dp (
   input  wire logic                   clock,
   input  wire opn2d_pkg::ctl_cmd_type cmd,
   input  wire logic [7:0]             table_index,
   input  wire logic [7:0]             table_value,
   input  wire logic signed [31:0]     x_coord,
   input  wire logic signed [31:0]     y_coord,
   input  wire logic                   ridged,
   input  wire logic [15:0]            persistence,
   input  wire logic [15:0]            lacunarity,
   output logic signed [15:0]          noise_value
);
   import opn2d_pkg::*;

   logic [7:0]         mem [TABLE_SIZE];
   logic [7:0]         rd_ff;
   logic [7:0]         raddr;

   logic signed [31:0] x_ff, y_ff;
   logic [31:0]        freq_ff, amp_ff;
   logic signed [63:0] total_ff;
   logic [36:0]        ampsum_ff;
   logic [23:0]        sx_ff, sy_ff;
   logic [31:0]        sqx_ff, sqy_ff;
   logic [15:0]        t3x_ff, t3y_ff;
   logic [20:0]        polyx_ff, polyy_ff;
   logic [16:0]        fu_ff, fv_ff;
   logic [7:0]         a_ff, b_ff, aa_ff, ab_ff, ba_ff, bb_ff;
   logic signed [18:0] g0_ff, g1_ff, g2_ff, g3_ff;
   logic signed [37:0] m0_ff, m1_ff;
   logic signed [20:0] l0_ff, l1_ff;
   logic signed [39:0] m2_ff;
   logic signed [21:0] n_ff;
   logic signed [19:0] term_ff;
   logic signed [52:0] ta_ff;
   logic [63:0]        rem_ff;
   logic [38:0]        dv_ff;
   logic [15:0]        q_ff;
   logic               neg_ff, ovf_ff;
   logic signed [15:0] res_ff;

   logic signed [64:0] prod_x, prod_y;
   logic [7:0]         cell_x, cell_y;
   logic [15:0]        fx, fy;
   logic [31:0]        cube_x, cube_y;
   logic [37:0]        poly_x, poly_y;
   logic [36:0]        fade_x, fade_y;
   logic signed [17:0] dx0, dx1, dy0, dy1;
   logic signed [19:0] d0, d1;
   logic signed [21:0] d2;
   logic signed [37:0] m0, m1;
   logic signed [39:0] m2;
   logic signed [21:0] abs_n;
   logic signed [22:0] r;
   logic signed [45:0] rr;
   logic signed [52:0] ta;
   logic [47:0]        amp_prod, freq_prod;
   logic [63:0]        mag;
   logic [63:0]        cand;
   logic [16:0]        qs;

   assign prod_x = x_ff * $signed({1'b0, freq_ff});
   assign prod_y = y_ff * $signed({1'b0, freq_ff});
   assign cell_x = sx_ff[23:16];
   assign cell_y = sy_ff[23:16];
   assign fx = sx_ff[15:0];
   assign fy = sy_ff[15:0];
   assign cube_x = sqx_ff[31:16] * fx;
   assign cube_y = sqy_ff[31:16] * fy;
   assign poly_x = 38'(sqx_ff) * 38'd6 + 38'hA00000000 - 38'(fx) * 38'd983040;
   assign poly_y = 38'(sqy_ff) * 38'd6 + 38'hA00000000 - 38'(fy) * 38'd983040;
   assign fade_x = 37'(t3x_ff) * 37'(polyx_ff);
   assign fade_y = 37'(t3y_ff) * 37'(polyy_ff);
   assign dx0 = $signed({2'b00, fx});
   assign dy0 = $signed({2'b00, fy});
   assign dx1 = dx0 - 18'sd65536;
   assign dy1 = dy0 - 18'sd65536;
   assign d0 = 20'(g1_ff) - 20'(g0_ff);
   assign d1 = 20'(g3_ff) - 20'(g2_ff);
   assign m0 = $signed({1'b0, fu_ff}) * d0;
   assign m1 = $signed({1'b0, fu_ff}) * d1;
   assign d2 = 22'(l1_ff) - 22'(l0_ff);
   assign m2 = $signed({1'b0, fv_ff}) * d2;
   assign abs_n = n_ff[21] ? -n_ff : n_ff;
   assign r = 23'sd65536 - 23'(abs_n);
   assign rr = r * r;
   assign ta = term_ff * $signed({1'b0, amp_ff});
   assign amp_prod = amp_ff * persistence;
   assign freq_prod = freq_ff * lacunarity;
   assign mag = total_ff[63] ? 64'(-total_ff) : 64'(total_ff);
   assign cand = {25'd0, dv_ff} << cmd.div_bit;

   always_comb begin
      case (cmd.phase)
         PH_ADDR_X:  raddr = cell_x;
         PH_ADDR_X1: raddr = cell_x + 8'd1;
         PH_ADDR_A:  raddr = a_ff;
         PH_ADDR_A1: raddr = a_ff + 8'd1;
         PH_ADDR_B:  raddr = b_ff;
         PH_ADDR_B1: raddr = b_ff + 8'd1;
         PH_ADDR_AA: raddr = aa_ff;
         PH_ADDR_BA: raddr = ba_ff;
         PH_ADDR_AB: raddr = ab_ff;
         PH_ADDR_BB: raddr = bb_ff;
         default:    raddr = cell_x;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.tbl_we) begin
         mem[table_index] <= table_value;
      end
      rd_ff <= mem[raddr];
   end

   always_ff @(posedge clock) begin
      if (cmd.init) begin
         x_ff <= x_coord;
         y_ff <= y_coord;
         freq_ff <= 32'd65536;
         amp_ff <= 32'd65536;
         total_ff <= '0;
         ampsum_ff <= '0;
      end
      if (cmd.run) begin
         unique case (cmd.phase)
            PH_SCALE: begin
               sx_ff <= prod_x[39:16];
               sy_ff <= prod_y[39:16];
            end
            PH_ADDR_X: begin
               sqx_ff <= fx * fx;
               sqy_ff <= fy * fy;
            end
            PH_ADDR_X1: begin
               a_ff <= rd_ff + cell_y;
               t3x_ff <= cube_x[31:16];
               t3y_ff <= cube_y[31:16];
               polyx_ff <= poly_x[36:16];
               polyy_ff <= poly_y[36:16];
            end
            PH_ADDR_A: begin
               b_ff <= rd_ff + cell_y;
               fu_ff <= fade_x[32:16];
               fv_ff <= fade_y[32:16];
            end
            PH_ADDR_A1: aa_ff <= rd_ff;
            PH_ADDR_B:  ab_ff <= rd_ff;
            PH_ADDR_B1: ba_ff <= rd_ff;
            PH_ADDR_AA: bb_ff <= rd_ff;
            PH_ADDR_BA: g0_ff <= grad_q16(rd_ff[2:0], dx0, dy0);
            PH_ADDR_AB: g1_ff <= grad_q16(rd_ff[2:0], dx1, dy0);
            PH_ADDR_BB: g2_ff <= grad_q16(rd_ff[2:0], dx0, dy1);
            PH_GRAD2:   g3_ff <= grad_q16(rd_ff[2:0], dx1, dy1);
            PH_LERP_M: begin
               m0_ff <= m0;
               m1_ff <= m1;
            end
            PH_LERP_A: begin
               l0_ff <= 21'(g0_ff) + 21'(m0_ff >>> 16);
               l1_ff <= 21'(g2_ff) + 21'(m1_ff >>> 16);
            end
            PH_LERP2_M: m2_ff <= m2;
            PH_LERP2_A: n_ff <= 22'(l0_ff) + 22'(m2_ff >>> 16);
            PH_RIDGE:   term_ff <= ridged ? 20'(rr >>> 16) : 20'(n_ff);
            PH_WEIGHT:  ta_ff <= ta;
            PH_ACC: begin
               total_ff <= total_ff + 64'(ta_ff);
               ampsum_ff <= ampsum_ff + 37'(amp_ff);
               amp_ff <= (|amp_prod[47:46]) ? 32'hFFFFFFFF : amp_prod[45:14];
               freq_ff <= (|freq_prod[47:44]) ? 32'hFFFFFFFF : freq_prod[43:12];
            end
            default: begin
            end
         endcase
      end
      if (cmd.div_check) begin
         neg_ff <= total_ff[63];
         rem_ff <= mag;
         dv_ff <= {ampsum_ff, 2'b00};
         ovf_ff <= (mag >= {9'd0, ampsum_ff, 2'b00, 16'd0});
         q_ff <= '0;
      end
      if (cmd.div_step) begin
         if (rem_ff >= cand) begin
            rem_ff <= rem_ff - cand;
            q_ff[cmd.div_bit] <= 1'b1;
         end
      end
      if (cmd.emit) begin
         res_ff <= neg_ff ? 16'(-$signed({1'b0, qs})) : $signed(qs[15:0]);
      end
   end

   always_comb begin
      if (neg_ff) begin
         qs = (ovf_ff || q_ff > 16'd32768) ? 17'd32768 : {1'b0, q_ff};
      end else begin
         qs = (ovf_ff || q_ff > 16'd32767) ? 17'd32767 : {1'b0, q_ff};
      end
   end

   assign noise_value = res_ff;

endmodule
`default_nettype wire

// ===== rtl/octave_perlin_noise_2d.sv =====
// channel   direction  ports                                  beat
// request   in         start/busy, req_op, req_table_*, req_* start & !busy
// response  out        rsp_valid, rsp_noise_value             rsp_valid, one cycle
// csr       in         csr_we, csr_index, csr_wdata           csr_we
//
// a load beat writes the table in the accept cycle and gives no response
// an evaluate beat keeps busy high while each octave runs the per-octave schedule
// and then while the 16-step divider runs; rsp_valid rises as busy falls
// synchronous active-high reset; the table holds nothing defined until loaded
// the response is not held off; the receiver takes it in its single cycle
`default_nettype none
module octave_perlin_noise_2d (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic               req_op,
   input  wire logic [7:0]         req_table_index,
   input  wire logic [7:0]         req_table_value,
   input  wire logic signed [31:0] req_x_coord,
   input  wire logic signed [31:0] req_y_coord,
   output logic                    rsp_valid,
   output logic signed [15:0]      rsp_noise_value,
   input  wire logic               csr_we,
   input  wire logic [1:0]         csr_index,
   input  wire logic [15:0]        csr_wdata
);
   import opn2d_pkg::*;

   logic [1:0]  mode_ff;
   logic [4:0]  octaves_ff;
   logic [15:0] persist_ff;
   logic [15:0] lacun_ff;
   ctl_cmd_type cmd;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_SINGLE;
         octaves_ff <= 5'd1;
         persist_ff <= 16'd16384;
         lacun_ff <= 16'd8192;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_MODE:        mode_ff <= csr_wdata[1:0];
            CSR_OCTAVES:     octaves_ff <= csr_wdata[4:0];
            CSR_PERSISTENCE: persist_ff <= csr_wdata;
            CSR_LACUNARITY:  lacun_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   opn2d_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .req_op       (req_op),
      .noise_mode   (mode_ff),
      .octave_count (octaves_ff),
      .cmd          (cmd),
      .busy         (busy),
      .rsp_valid    (rsp_valid)
   );

   opn2d_dp u_dp (
      .clock       (clock),
      .cmd         (cmd),
      .table_index (req_table_index),
      .table_value (req_table_value),
      .x_coord     (req_x_coord),
      .y_coord     (req_y_coord),
      .ridged      (mode_ff == MODE_RIDGED),
      .persistence (persist_ff),
      .lacunarity  (lacun_ff),
      .noise_value (rsp_noise_value)
   );

endmodule
`default_nettype wire
